FILE: src/itr_pkg.sv
package itr_pkg;

    // Radix register limits
    localparam int unsigned RADIX_W     = 6;
    localparam logic [5:0]  RADIX_MIN   = 6'd2;
    localparam logic [5:0]  RADIX_MAX   = 6'd36;
    localparam logic [5:0]  RADIX_RESET = 6'd10;

    // Digit store geometry
    localparam int unsigned STORE_DEPTH = 64;
    localparam int unsigned STORE_AW    = 6;
    localparam int unsigned COUNT_W     = 7;

    // Character codes
    localparam logic [6:0]  CHAR_ZERO   = 7'd48;
    localparam logic [6:0]  CHAR_LOWER_A = 7'd97;
    localparam logic [5:0]  DIGIT_NINE  = 6'd9;
    localparam logic [5:0]  DIGIT_TEN   = 6'd10;

    // Conversion sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } t_state;

    // Divider status towards the sequencer
    typedef struct packed {
        logic       done;
        logic       nonzero;
        logic [5:0] rem;
    } t_div_status;

    // Map a digit value to its ASCII code
    function automatic logic [6:0] digit_to_char(input logic [5:0] d);
        logic [6:0] c;
        if (d > DIGIT_NINE) begin
            c = {1'b0, d - DIGIT_TEN} + CHAR_LOWER_A;
        end else begin
            c = {1'b0, d} + CHAR_ZERO;
        end
        return c;
    endfunction

    // Clamp a radix write into the legal range
    function automatic logic [5:0] clamp_radix(input logic [5:0] r);
        logic [5:0] c;
        if (r < RADIX_MIN) begin
            c = RADIX_MIN;
        end else if (r > RADIX_MAX) begin
            c = RADIX_MAX;
        end else begin
            c = r;
        end
        return c;
    endfunction

endpackage

FILE: src/itr_div.sv
module itr_div import itr_pkg::*; #(
    parameter int unsigned VALUE_WIDTH = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [VALUE_WIDTH-1:0] i_dividend,
    input  logic [5:0]             i_radix,
    output logic [VALUE_WIDTH-1:0] o_quotient,
    output t_div_status            o_status
);

    localparam int unsigned CW = $clog2(VALUE_WIDTH);

    logic                   r_busy;
    logic                   r_done;
    logic [CW-1:0]          r_cnt;
    logic [VALUE_WIDTH-1:0] r_quo;
    logic [5:0]             r_rem;
    logic                   r_nz;

    logic [6:0]             trial;
    logic [6:0]             diff;
    logic                   ge;
    logic [5:0]             n_rem;

    // Restoring step: bring down one dividend bit, subtract the radix if it fits
    always_comb begin
        trial = {r_rem, r_quo[VALUE_WIDTH-1]};
        diff  = trial - {1'b0, i_radix};
        ge    = (trial >= {1'b0, i_radix});
        n_rem = ge ? diff[5:0] : trial[5:0];
    end

    // Control: load, count bits, flag completion
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_nz   <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CW'(VALUE_WIDTH - 1);
            r_nz   <= 1'b0;
        end else if (r_busy) begin
            r_nz  <= r_nz | ge;
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // Datapath: shift quotient bits in as the dividend shifts out
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= {r_quo[VALUE_WIDTH-2:0], ge};
            r_rem <= n_rem;
        end
    end

    assign o_quotient       = r_quo;
    assign o_status.done    = r_done;
    assign o_status.nonzero = r_nz;
    assign o_status.rem     = r_rem;

`ifndef NO_ASSERTIONS
    // Remainder stays below the radix once a pass is finished
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> ({1'b0, r_rem} < {1'b0, i_radix}))
        else $error("divider remainder not below radix");

    // Done never overlaps an active pass
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("divider done while busy");

    // A finishing pass raises done on the next cycle
    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_cnt == '0 && !i_start) |=> r_done)
        else $error("divider pass ended without done");
`endif

endmodule

FILE: src/integer_to_text_radix.sv
// Integer to text converter, radix 2 to 36.
// Command channel: present value and signed_mode with start high; the item
// is taken at a clock edge where start is high and busy is low. busy stays
// high until the final digit has been shown.
// Result channel: one digit per cycle on o_char_code, o_negative and o_last,
// marked by o_valid for exactly one cycle, most significant digit first.
// o_last marks the least significant digit. The receiver cannot stall, so
// every digit must be taken in the cycle it is shown.
// Configuration: i_cfg_we writes i_cfg_wdata into the radix register,
// clamped to 2..36; write it only while busy is low.
// Sequence: each digit costs one pass of the bit-serial divider, then the
// digits are read back from the digit store at one per cycle.
// Reset: synchronous, active low; radix returns to 10, busy drops and no
// result is shown. The digit store needs no clearing.
module integer_to_text_radix import itr_pkg::*; #(
    parameter int unsigned VALUE_WIDTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] i_value,
    input  logic        i_signed_mode,
    input  logic        i_cfg_we,
    input  logic [5:0]  i_cfg_wdata,
    output logic        o_valid,
    output logic [6:0]  o_char_code,
    output logic        o_negative,
    output logic        o_last
);

    t_state                 r_state;
    t_state                 n_state;
    logic [5:0]             r_radix;
    logic [COUNT_W-1:0]     r_count;
    logic [STORE_AW-1:0]    r_ptr;
    logic                   r_sign;
    logic                   r_rd_vld;
    logic                   r_rd_last;
    logic [5:0]             r_rd_data;
    logic [5:0]             mem [STORE_DEPTH];

    logic                   accept;
    logic [VALUE_WIDTH-1:0] in_val;
    logic                   in_neg;
    logic [VALUE_WIDTH-1:0] in_mag;
    logic                   div_start;
    logic [VALUE_WIDTH-1:0] div_dividend;
    logic [VALUE_WIDTH-1:0] div_quo;
    t_div_status            div_st;
    logic                   more_digits;
    logic                   st_write;
    logic                   st_read;

    // Take the magnitude of the incoming value
    always_comb begin
        in_val = i_value[VALUE_WIDTH-1:0];
        in_neg = i_signed_mode & in_val[VALUE_WIDTH-1];
        in_mag = in_neg ? (~in_val + 1'b1) : in_val;
    end

    assign accept      = start & ~busy;
    assign more_digits = div_st.nonzero && (r_count[STORE_AW-1:0] != STORE_AW'(STORE_DEPTH - 1));

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) n_state = ST_DIV;
            end
            ST_DIV: begin
                if (div_st.done && !more_digits) n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (r_ptr == '0) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        div_start    = 1'b0;
        div_dividend = in_mag;
        st_write     = 1'b0;
        st_read      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                div_start = accept;
            end
            ST_DIV: begin
                st_write     = div_st.done;
                div_start    = div_st.done && more_digits;
                div_dividend = div_quo;
            end
            ST_EMIT: begin
                st_read = 1'b1;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    itr_div #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_radix    (r_radix),
        .o_quotient (div_quo),
        .o_status   (div_st)
    );

    // State, radix and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_radix   <= RADIX_RESET;
            r_count   <= '0;
            r_ptr     <= '0;
            r_sign    <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_rd_last <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= st_read;
            if (i_cfg_we) r_radix <= clamp_radix(i_cfg_wdata);
            if (accept) begin
                r_count <= '0;
                r_sign  <= in_neg;
            end
            if (st_write) begin
                r_count <= r_count + 1'b1;
                r_ptr   <= r_count[STORE_AW-1:0];
            end
            if (st_read) begin
                r_ptr     <= r_ptr - 1'b1;
                r_rd_last <= (r_ptr == '0);
            end
        end
    end

    // Digit store: write remainders in order, read back from the top
    always_ff @(posedge i_clk) begin
        if (st_write) mem[r_count[STORE_AW-1:0]] <= div_st.rem;
        if (st_read) r_rd_data <= mem[r_ptr];
    end

    assign busy        = (r_state != ST_IDLE) | r_rd_vld;
    assign o_valid     = r_rd_vld;
    assign o_char_code = digit_to_char(r_rd_data);
    assign o_negative  = r_sign;
    assign o_last      = r_rd_vld & r_rd_last;

`ifndef NO_ASSERTIONS
    // A digit transfer only happens inside a busy run
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("digit shown while not busy");

    // An accepted item raises busy through the registered state
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("busy not raised after accept");

    // Radix stays within its legal range
    a_radix_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_radix >= RADIX_MIN) && (r_radix <= RADIX_MAX))
        else $error("radix out of range");

    // Divider completes only while digits are being produced
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_st.done |-> (r_state == ST_DIV))
        else $error("divider done outside digit generation");

    // The last digit ends the run
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |=> !o_valid)
        else $error("digit shown after last");
`endif

endmodule

FILE: verif/itr_digit_checker.sv
`timescale 1ns / 1ps

module itr_digit_checker import itr_pkg::*; #(
    parameter int unsigned VALUE_WIDTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [63:0] i_value,
    input  logic        i_signed_mode,
    input  logic        i_cfg_we,
    input  logic [5:0]  i_cfg_wdata,
    input  logic        i_valid,
    input  logic [6:0]  i_char_code,
    input  logic        i_negative,
    input  logic        i_last,
    output int unsigned o_fail_count,
    output int unsigned o_awaited
);

    localparam logic [63:0] VALUE_MASK = {64{1'b1}} >> (64 - VALUE_WIDTH);
    localparam int unsigned REPORT_LIMIT = 10;

    typedef struct packed {
        logic [6:0] char_code;
        logic       negative;
        logic       last;
    } t_digit;

    t_digit      awaited_digits[$];
    t_digit      oldest;
    logic [5:0]  radix_now;
    int unsigned reported;

    // ASCII code of one digit value
    function automatic logic [6:0] ascii_of(input logic [5:0] d);
        if (d > DIGIT_NINE) begin
            return CHAR_LOWER_A + 7'(d) - 7'(DIGIT_TEN);
        end
        return CHAR_ZERO + 7'(d);
    endfunction

    // Convert one number and queue its digits, most significant first
    function automatic void queue_digits_of(input logic [63:0] raw, input logic signed_in,
                                            input logic [5:0] base);
        logic [63:0] mag;
        logic        neg;
        logic [5:0]  held [64];
        int          n;
        t_digit      d;
        mag = raw & VALUE_MASK;
        neg = signed_in && mag[VALUE_WIDTH-1];
        // take the magnitude; the most negative value maps onto itself unsigned
        if (neg) begin
            mag = (~mag + 64'd1) & VALUE_MASK;
        end
        n = 0;
        do begin
            held[n] = 6'(mag % 64'(base));
            mag     = mag / 64'(base);
            n++;
        end while (mag != 64'd0 && n < 64);
        for (int k = n - 1; k >= 0; k--) begin
            d.char_code = ascii_of(held[k]);
            d.negative  = neg;
            d.last      = (k == 0);
            awaited_digits.push_back(d);
        end
    endfunction

    // Compare digits, then pick up new transfers and radix writes
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            radix_now = RADIX_RESET;
            awaited_digits.delete();
            reported     = 0;
            o_fail_count = 0;
        end else begin
            if (i_valid) begin
                if (awaited_digits.size() == 0) begin
                    if (reported < REPORT_LIMIT) begin
                        $display("%0t: unexpected digit: char_code %0d negative %0b last %0b",
                                 $realtime, i_char_code, i_negative, i_last);
                    end
                    reported++;
                    o_fail_count++;
                end else begin
                    oldest = awaited_digits.pop_front();
                    if (oldest.char_code !== i_char_code || oldest.negative !== i_negative
                            || oldest.last !== i_last) begin
                        if (reported < REPORT_LIMIT) begin
                            $display("%0t: digit mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                                     $realtime, oldest.char_code, oldest.negative, oldest.last,
                                     i_char_code, i_negative, i_last);
                        end
                        reported++;
                        o_fail_count++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                queue_digits_of(i_value, i_signed_mode, radix_now);
            end
            // hold the clamped radix as the block stores it
            if (i_cfg_we) begin
                if (i_cfg_wdata < RADIX_MIN) begin
                    radix_now = RADIX_MIN;
                end else if (i_cfg_wdata > RADIX_MAX) begin
                    radix_now = RADIX_MAX;
                end else begin
                    radix_now = i_cfg_wdata;
                end
            end
        end
        o_awaited = awaited_digits.size();
    end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench import itr_pkg::*; ();

    localparam int unsigned WATCHDOG_LIMIT = 20000;
    localparam int unsigned SETTLE_CYCLES  = 150;
    localparam int unsigned PHASES         = 12;
    localparam int unsigned PHASE_ITEMS    = 35;
    localparam logic [63:0] ALL_ONES       = {64{1'b1}};
    localparam logic [63:0] MOST_NEG       = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MOST_POS       = 64'h7FFF_FFFF_FFFF_FFFF;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        start         = 1'b0;
    logic [63:0] i_value       = 64'd0;
    logic        i_signed_mode = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [5:0]  i_cfg_wdata   = 6'd0;
    logic        busy;
    logic        o_valid;
    logic [6:0]  o_char_code;
    logic        o_negative;
    logic        o_last;

    int unsigned fail_count;
    int unsigned awaited;
    int unsigned quiet_cycles = 0;
    bit          gaps_on      = 1'b1;
    logic [5:0]  radix_set    = RADIX_RESET;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    integer_to_text_radix dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_value      (i_value),
        .i_signed_mode(i_signed_mode),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_valid      (o_valid),
        .o_char_code  (o_char_code),
        .o_negative   (o_negative),
        .o_last       (o_last)
    );

    itr_digit_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_value      (i_value),
        .i_signed_mode(i_signed_mode),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_valid      (o_valid),
        .i_char_code  (o_char_code),
        .i_negative   (o_negative),
        .i_last       (o_last),
        .o_fail_count (fail_count),
        .o_awaited    (awaited)
    );

    // Drop the run when nothing has moved for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one number; return once the transfer has happened and start is low
    task automatic send_number(input logic [63:0] v, input logic s);
        do @(negedge i_clk); while (busy);
        while (gaps_on && $urandom_range(0, 99) < 26) begin
            @(negedge i_clk);
        end
        start         <= 1'b1;
        i_value       <= v;
        i_signed_mode <= s;
        @(negedge i_clk);
        start <= 1'b0;
    endtask

    // Hold until every awaited digit has come and the block is idle
    task automatic wait_drained;
        while (awaited != 0 || busy) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    // Write the radix register while idle and track the clamped value
    task automatic write_radix(input logic [5:0] r);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= r;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (r < RADIX_MIN) begin
            radix_set = RADIX_MIN;
        end else if (r > RADIX_MAX) begin
            radix_set = RADIX_MAX;
        end else begin
            radix_set = r;
        end
    endtask

    // Random number: full width, shortened, small, near a power of the radix, or corner
    function automatic logic [63:0] pick_value(input logic [5:0] base);
        logic [63:0] full;
        logic [63:0] p;
        int unsigned kind;
        int unsigned k;
        full = {$urandom, $urandom};
        kind = $urandom_range(0, 99);
        if (kind < 40) begin
            return full;
        end
        if (kind < 70) begin
            return full >> $urandom_range(1, 63);
        end
        if (kind < 80) begin
            return 64'($urandom_range(0, base + 2));
        end
        if (kind < 90) begin
            p = 64'd1;
            k = $urandom_range(1, 64);
            while (k > 0 && p <= ALL_ONES / 64'(base)) begin
                p = p * 64'(base);
                k--;
            end
            return p + 64'($urandom_range(0, 2)) - 64'd1;
        end
        case ($urandom_range(0, 4))
            0: return 64'd0;
            1: return ALL_ONES;
            2: return MOST_NEG;
            3: return MOST_POS;
            default: return 64'd1;
        endcase
    endfunction

    initial begin : stimulus
        logic [5:0] r;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset radix: zero, extremes, most negative, decimal boundaries
        send_number(64'd0, 1'b0);
        send_number(64'd0, 1'b1);
        send_number(ALL_ONES, 1'b0);
        send_number(ALL_ONES, 1'b1);
        send_number(MOST_NEG, 1'b1);
        send_number(MOST_NEG, 1'b0);
        send_number(MOST_POS, 1'b1);
        send_number(64'd9, 1'b0);
        send_number(64'd10, 1'b1);
        send_number(64'd12345678901234567890, 1'b0);

        // write above the range: clamps to base 36, exercise 'z'
        write_radix(6'd63);
        send_number(64'd35, 1'b0);
        send_number(64'd36, 1'b0);
        send_number(ALL_ONES, 1'b0);
        send_number(64'hFFFF_FFFF_FFFF_FFDD, 1'b1);

        // write below the range: clamps to base 2, longest runs
        write_radix(6'd0);
        send_number(ALL_ONES, 1'b0);
        send_number(MOST_NEG, 1'b1);
        send_number(64'd0, 1'b1);
        send_number(64'h5555_5555_5555_5555, 1'b0);

        // random phases, each with its own radix setting
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: r = 6'd1;
                1: r = 6'd2;
                2: r = 6'd3;
                3: r = 6'd7;
                4: r = 6'd8;
                5: r = 6'd10;
                6: r = 6'd16;
                7: r = 6'd35;
                8: r = 6'd37;
                9: r = 6'd36;
                default: r = 6'($urandom_range(0, 63));
            endcase
            write_radix(r);
            gaps_on = !(ph == 4 || ph == 5);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_number(pick_value(radix_set), 1'($urandom_range(0, 1)));
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && awaited == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
